### sv/pld_pkg.sv
// shared constants and types for the power-to-dac linearizer
// no dependencies; imported by pld_cal_table and the top level
package pld_pkg;

  localparam int unsigned PWR_W            = 15;
  localparam int unsigned CODE_W           = 16;
  localparam int unsigned TABLE_POINTS_DEF = 20;

  localparam logic [PWR_W-1:0]  MAX_POWER_RST = 15'd1000;
  localparam logic [PWR_W-1:0]  MIN_POWER_RST = 15'd0;
  localparam logic [CODE_W-1:0] FULL_SCALE_RST = 16'd4095;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_MAX_POWER  = 2'd0,
    CFG_MIN_POWER  = 2'd1,
    CFG_FULL_SCALE = 2'd2,
    CFG_CAL_ENABLE = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MULK,
    ST_MULF,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### sv/pld_cal_table.sv
// calibration point memory with one write and one registered read port
// entries never written read as zero; depends on pld_pkg
module pld_cal_table import pld_pkg::*; #(
  parameter int unsigned TABLE_POINTS = TABLE_POINTS_DEF,
  localparam int unsigned KW = $clog2(TABLE_POINTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [KW-1:0]    waddr_i,
  input  logic [PWR_W-1:0] wdata_i,
  input  logic [KW-1:0]    raddr_i,
  output logic [PWR_W-1:0] rdata_o
);

  logic [PWR_W-1:0]        mem_q [TABLE_POINTS];
  logic [TABLE_POINTS-1:0] valid_q;
  logic [PWR_W-1:0]        rdata_q;
  logic                    rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### sv/piecewise_power_to_dac_linearizer.sv
// Power-to-DAC linearizer: one request in flight at a time. A table write item
// gives no result. A convert item is accepted only when the engine is idle; a
// zero clamped power gives code zero with no arithmetic, and in calibrated mode a
// power beyond the table gives full scale once the scan ends. In calibrated mode
// the figure is set by a scan of the calibration memory, one entry per cycle,
// followed by two 16-step shift-add multiplications (segment times span, then
// times full scale) and a 16-step restoring division, all one bit per cycle;
// proportional mode runs only the multiplication by full scale and the division. A
// finished result waits in an output register so the next item can be accepted
// meanwhile; the engine returns to idle once that register is free or being read.
// depends on pld_pkg and pld_cal_table
module piecewise_power_to_dac_linearizer import pld_pkg::*; #(
  parameter int unsigned TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index[4:0], entry_value[19:5], power_request[35:20], zero[39:36]
  input  logic [39:0] s_axis_tdata,
  // command[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // dac_code[15:0], power_was_clamped[16], zero[23:17]
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned KW = $clog2(TABLE_POINTS);
  localparam int unsigned DW = PWR_W + KW;
  localparam int unsigned AW = CODE_W + DW;

  state_e state_q, state_d;

  logic [PWR_W-1:0]  max_q, min_q;
  logic [CODE_W-1:0] fs_q;
  logic              cal_en_q;

  logic [3:0]        cnt_q, cnt_d;
  logic [PWR_W-1:0]  power_q, power_d;
  logic              clamp_q, clamp_d;
  logic [KW-1:0]     k_q, k_d;
  logic [PWR_W-1:0]  lo_q, lo_d;
  logic [PWR_W-1:0]  r_q, r_d;
  logic [DW-1:0]     dvs_q, dvs_d;
  logic [DW-1:0]     a_q, a_d;
  logic [CODE_W-1:0] b_q, b_d;
  logic [AW-1:0]     acc_q, acc_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic              m_valid_q, m_valid_d;
  logic [CODE_W-1:0] m_code_q;
  logic              m_clamp_q;
  logic              load_out;

  logic              in_acc;
  logic [4:0]        in_idx;
  logic [PWR_W-1:0]  in_val;
  logic [15:0]       in_pwr;
  logic signed [16:0] req_s, max_s, min_s;
  logic [PWR_W-1:0]  clamped_pwr;
  logic              clamp_flag;

  logic              tbl_we;
  logic [KW-1:0]     tbl_raddr;
  logic [PWR_W-1:0]  hi;
  logic [PWR_W-1:0]  span;

  logic [AW-1:0]     prod;
  logic [DW:0]       div_t, div_sub;
  logic              div_ge;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_idx = s_axis_tdata[4:0];
  assign in_val = s_axis_tdata[19:5];
  assign in_pwr = s_axis_tdata[35:20];

  assign tbl_we = in_acc && (cmd_e'(s_axis_tuser[0]) == CMD_WRITE)
                  && ({2'b00, in_idx} < 7'(TABLE_POINTS));

  pld_cal_table #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (tbl_we),
    .waddr_i(KW'(in_idx)),
    .wdata_i(in_val),
    .raddr_i(tbl_raddr),
    .rdata_o(hi)
  );

  // clamp against max first, then min
  always_comb begin
    req_s       = {in_pwr[15], in_pwr};
    max_s       = {2'b00, max_q};
    min_s       = {2'b00, min_q};
    clamp_flag  = 1'b0;
    if (req_s > max_s) begin
      req_s      = max_s;
      clamp_flag = 1'b1;
    end
    if (req_s < min_s) begin
      req_s      = min_s;
      clamp_flag = 1'b1;
    end
    clamped_pwr = req_s[PWR_W-1:0];
  end

  assign span    = hi - lo_q;
  assign prod    = {acc_q[AW-2:0], 1'b0} + (b_q[CODE_W-1] ? AW'(a_q) : '0);
  assign div_t   = {rem_q, b_q[CODE_W-1]};
  assign div_sub = div_t - {1'b0, dvs_q};
  assign div_ge  = div_t >= {1'b0, dvs_q};

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    power_d   = power_q;
    clamp_d   = clamp_q;
    k_d       = k_q;
    lo_d      = lo_q;
    r_d       = r_q;
    dvs_d     = dvs_q;
    a_d       = a_q;
    b_d       = b_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    code_d    = code_q;
    load_out  = 1'b0;
    tbl_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd_e'(s_axis_tuser[0]) == CMD_CONVERT)) begin
          power_d = clamped_pwr;
          clamp_d = clamp_flag;
          k_d     = '0;
          lo_d    = '0;
          cnt_d   = '0;
          acc_d   = '0;
          if (clamped_pwr == '0) begin
            code_d  = '0;
            state_d = ST_DONE;
          end else if (cal_en_q) begin
            state_d = ST_SCAN;
          end else if (clamped_pwr > max_q) begin
            code_d  = fs_q;
            state_d = ST_DONE;
          end else begin
            a_d     = DW'(clamped_pwr);
            b_d     = fs_q;
            dvs_d   = DW'(max_q);
            state_d = ST_MULF;
          end
        end
      end
      ST_SCAN: begin
        tbl_raddr = (k_q == KW'(TABLE_POINTS - 1)) ? k_q : k_q + KW'(1);
        if ((power_q > lo_q) && (power_q <= hi)) begin
          r_d     = power_q - lo_q;
          a_d     = DW'(span);
          b_d     = CODE_W'(k_q);
          dvs_d   = DW'(DW'(span) * DW'(TABLE_POINTS));
          state_d = ST_MULK;
        end else if (k_q == KW'(TABLE_POINTS - 1)) begin
          code_d  = fs_q;
          state_d = ST_DONE;
        end else begin
          lo_d = hi;
          k_d  = k_q + KW'(1);
        end
      end
      ST_MULK: begin
        acc_d = prod;
        b_d   = {b_q[CODE_W-2:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          a_d     = prod[DW-1:0] + DW'(r_q);
          b_d     = fs_q;
          acc_d   = '0;
          state_d = ST_MULF;
        end
      end
      ST_MULF: begin
        acc_d = prod;
        b_d   = {b_q[CODE_W-2:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          rem_d   = prod[AW-1:CODE_W];
          b_d     = prod[CODE_W-1:0];
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = div_ge ? div_sub[DW-1:0] : div_t[DW-1:0];
        b_d   = {b_q[CODE_W-2:0], div_ge};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          code_d  = {b_q[CODE_W-2:0], div_ge};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (load_out) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      max_q     <= MAX_POWER_RST;
      min_q     <= MIN_POWER_RST;
      fs_q      <= FULL_SCALE_RST;
      cal_en_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_MAX_POWER:  max_q    <= cfg_data_i[PWR_W-1:0];
          CFG_MIN_POWER:  min_q    <= cfg_data_i[PWR_W-1:0];
          CFG_FULL_SCALE: fs_q     <= cfg_data_i;
          CFG_CAL_ENABLE: cal_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    power_q <= power_d;
    clamp_q <= clamp_d;
    k_q     <= k_d;
    lo_q    <= lo_d;
    r_q     <= r_d;
    dvs_q   <= dvs_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    code_q  <= code_d;
    if (load_out) begin
      m_code_q  <= code_q;
      m_clamp_q <= clamp_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_clamp_q, m_code_q};

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < dvs_q))
    else $error("division remainder not below divisor");

  // a finished code never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (code_q <= fs_q))
    else $error("dac code above full scale");

  // leaving done always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> m_axis_tvalid)
    else $error("result lost on completion");

  // no request is taken while the arithmetic is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULK || state_q == ST_MULF || state_q == ST_DIV) |-> !s_axis_tready)
    else $error("input accepted while engine busy");

endmodule

### test/pld_result_checker.sv
`timescale 1ns / 1ps
// result checker for the power-to-dac linearizer: mirrors register and table writes,
// predicts the dac code of each convert request and compares it with the result stream
// depends on pld_pkg
module pld_result_checker import pld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [39:0] in_data_i,
  input  logic [0:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  localparam int unsigned NPOINTS = TABLE_POINTS_DEF;

  typedef struct packed {
    logic [CODE_W-1:0] dac_code;
    logic              clamped;
  } dac_result_t;

  logic [PWR_W-1:0]  max_power;
  logic [PWR_W-1:0]  min_power;
  logic [CODE_W-1:0] full_scale;
  logic              cal_enable;
  logic [PWR_W-1:0]  cal_points [NPOINTS];
  dac_result_t       dac_expect_q [$];

  function automatic dac_result_t predict_dac_code(input logic signed [15:0] request);
    dac_result_t       res;
    int                power;
    int                lo;
    int                hi;
    bit                hit;
    longint unsigned   code;
    longint unsigned   span;
    longint unsigned   num;
    power = request;
    res.clamped = 1'b0;
    if (power > int'(max_power)) begin
      power = int'(max_power);
      res.clamped = 1'b1;
    end
    if (power < int'(min_power)) begin
      power = int'(min_power);
      res.clamped = 1'b1;
    end
    if (cal_enable) begin
      code = full_scale;
      hit = 1'b0;
      lo = 0;
      if (power <= 0) begin
        code = 0;
      end else begin
        for (int k = 0; k < NPOINTS; k++) begin
          hi = int'(cal_points[k]);
          if (k > 0) lo = int'(cal_points[k-1]);
          if (!hit && power > lo && power <= hi) begin
            span = longint'(hi - lo);
            num = longint'(k) * span + longint'(power - lo);
            code = (longint'(full_scale) * num) / (longint'(NPOINTS) * span);
            hit = 1'b1;
          end
        end
      end
    end else if (max_power == '0) begin
      code = (power > 0) ? longint'(full_scale) : 0;
    end else begin
      code = (longint'(power) * longint'(full_scale)) / longint'(max_power);
    end
    if (code > full_scale) code = full_scale;
    res.dac_code = code[CODE_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dac_result_t got;
    dac_result_t want;
    logic [4:0]  idx;
    if (!rst_ni) begin
      max_power = MAX_POWER_RST;
      min_power = MIN_POWER_RST;
      full_scale = FULL_SCALE_RST;
      cal_enable = 1'b0;
      for (int k = 0; k < NPOINTS; k++) cal_points[k] = '0;
      dac_expect_q.delete();
      fail_count_o = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_MAX_POWER:  max_power = cfg_data_i[PWR_W-1:0];
          CFG_MIN_POWER:  min_power = cfg_data_i[PWR_W-1:0];
          CFG_FULL_SCALE: full_scale = cfg_data_i;
          CFG_CAL_ENABLE: cal_enable = cfg_data_i[0];
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.dac_code = out_data_i[15:0];
        got.clamped = out_data_i[16];
        if (dac_expect_q.size() == 0) begin
          $error("result with no request waiting: dac_code %0d", got.dac_code);
          fail_count_o++;
        end else begin
          want = dac_expect_q.pop_front();
          if (got.dac_code !== want.dac_code) begin
            $error("dac_code mismatch: expected %0d, actual %0d", want.dac_code, got.dac_code);
            fail_count_o++;
          end
          if (got.clamped !== want.clamped) begin
            $error("power_was_clamped mismatch: expected %0d, actual %0d",
                   want.clamped, got.clamped);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        idx = in_data_i[4:0];
        if (cmd_e'(in_user_i[0]) == CMD_WRITE) begin
          if (idx < NPOINTS) cal_points[idx] = in_data_i[19:5];
        end else begin
          dac_expect_q.push_back(predict_dac_code(in_data_i[35:20]));
        end
      end
      outstanding_o <= dac_expect_q.size();
    end
  end

endmodule

### test/tb_piecewise_power_to_dac_linearizer.sv
`timescale 1ns / 1ps
// testbench top for the power-to-dac linearizer: clock, reset, register writes,
// directed and random request streams with random stalls; verdict from pld_result_checker
// depends on pld_pkg, piecewise_power_to_dac_linearizer and pld_result_checker
module tb_piecewise_power_to_dac_linearizer;
  import pld_pkg::*;

  localparam int unsigned NPOINTS = TABLE_POINTS_DEF;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  int send_idle_pct;
  int recv_idle_pct;
  int item_count;
  int stall_cycles;
  int max_p;
  int min_p;
  bit cal_on;
  int table_seen [NPOINTS];

  piecewise_power_to_dac_linearizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pld_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(input cmd_e cmd, input logic [4:0] idx, input logic [14:0] val,
                              input logic [15:0] pw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'b0, pw, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_write(input int idx, input int val);
    send_request(CMD_WRITE, 5'(idx), 15'(val), 16'($urandom));
    if (idx < NPOINTS) begin
      table_seen[idx] = val;
      item_count++;
    end
  endtask

  task automatic send_convert(input int pw);
    send_request(CMD_CONVERT, 5'($urandom), 15'($urandom), 16'(pw));
    item_count++;
  endtask

  // drop valid, wait for every pending result, then let the engine go quiet
  task automatic settle_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input int val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= 16'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int mx, input int mn, input int fs, input bit cal);
    settle_pipeline();
    write_reg(CFG_MAX_POWER, mx);
    write_reg(CFG_MIN_POWER, mn);
    write_reg(CFG_FULL_SCALE, fs);
    write_reg(CFG_CAL_ENABLE, int'(cal));
    max_p = mx;
    min_p = mn;
    cal_on = cal;
  endtask

  function automatic int pick_power();
    int top;
    int p;
    int sel;
    top = max_p;
    if (cal_on) begin
      top = 0;
      for (int k = 0; k < NPOINTS; k++) if (table_seen[k] > top) top = table_seen[k];
    end
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3, 4, 5: p = int'($urandom_range(0, top + 40)) - 20;
      6: p = table_seen[$urandom_range(NPOINTS - 1)] + int'($urandom_range(0, 2)) - 1;
      7: p = ($urandom_range(1) ? max_p : min_p) + int'($urandom_range(0, 2)) - 1;
      8: p = int'($signed(16'($urandom)));
      default: p = $urandom_range(1) ? 32767 : -32768;
    endcase
    if (p > 32767) p = 32767;
    return p;
  endfunction

  // one setting, an optional table load, then a burst of mostly convert requests
  task automatic random_round();
    int  mx;
    int  mn;
    int  fs;
    int  sel;
    int  prev;
    int  step_max;
    int  val;
    bit  cal;
    sel = $urandom_range(9);
    mx = (sel == 0) ? 1 : (sel == 1) ? 32767 :
         (sel < 5) ? int'($urandom_range(1, 2000)) : int'($urandom_range(1, 32767));
    sel = $urandom_range(9);
    mn = (sel < 6) ? 0 : (sel < 8) ? int'($urandom_range(0, mx / 4)) :
         (sel == 8) ? int'($urandom_range(0, 32767)) : 32767;
    sel = $urandom_range(9);
    fs = (sel == 0) ? 1 : (sel == 1) ? 65535 :
         (sel < 5) ? 4095 : int'($urandom_range(1, 65535));
    cal = ($urandom_range(9) < 6);
    set_config(mx, mn, fs, cal);
    if (cal) begin
      if ($urandom_range(9) < 8) begin
        prev = $urandom_range(0, mx / 20 + 1);
        step_max = mx / 20 + 2;
        for (int k = 0; k < NPOINTS; k++) begin
          if ($urandom_range(19) == 0) val = $urandom_range(0, 32767);
          else if ($urandom_range(7) == 0) val = prev;
          else val = prev + int'($urandom_range(1, step_max));
          if (val > 32767) val = 32767;
          send_write(k, val);
          prev = val;
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_write($urandom_range(0, 31), $urandom_range(0, 32767));
      end
    end
    repeat ($urandom_range(10, 40)) begin
      if ($urandom_range(19) == 0) send_write($urandom_range(0, 31), $urandom_range(0, 32767));
      else send_convert(pick_power());
    end
  endtask

  initial begin
    int phase;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MAX_POWER;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_WRITE;
    send_idle_pct = 17;
    recv_idle_pct = 88;
    stall_cycles = 0;
    item_count = 0;
    max_p = 1000;
    min_p = 0;
    cal_on = 1'b0;
    for (int k = 0; k < NPOINTS; k++) table_seen[k] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // proportional mode at reset values, clamps at both ends
    send_convert(0);
    send_convert(1);
    send_convert(999);
    send_convert(1000);
    send_convert(1001);
    send_convert(32767);
    send_convert(-1);
    send_convert(-32768);
    // zero max power, then min above max
    set_config(0, 0, 4095, 1'b0);
    send_convert(0);
    send_convert(5);
    set_config(0, 10, 4095, 1'b0);
    send_convert(0);
    // table mode, out-of-range entry writes, non-positive power, beyond the table
    set_config(32767, 0, 65535, 1'b1);
    send_write(0, 32767);
    send_write(19, 0);
    send_write(20, 5);
    send_write(31, 7);
    send_convert(32767);
    send_convert(16384);
    send_convert(0);
    send_convert(-32768);
    send_write(0, 100);
    send_convert(200);
    send_convert(100);
    set_config(32767, 32767, 65535, 1'b0);
    send_convert(0);

    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      phase = item_count * 3 / RANDOM_ITEMS;
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 17 : 0;
      random_round();
    end

    settle_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
